// ===== rtl/mtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse text codec package
// Shared types, byte codes and the code table lookups for encode and decode.
// ----------------------------------------------------------------------------
package mtc_pkg;

   // Longest group that the decoder gathers.
   localparam int unsigned MAX_GROUP_LEN = 7;

   // Byte codes used on the streams.
   localparam logic [7:0] SEP_BYTE   = 8'h7C;  // '|'
   localparam logic [7:0] DOT_BYTE   = 8'h2E;  // '.'
   localparam logic [7:0] DASH_BYTE  = 8'h2D;  // '-'
   localparam logic [7:0] SPACE_BYTE = 8'h20;  // ' '
   localparam logic [7:0] BANG_BYTE  = 8'h21;  // '!'
   localparam logic [7:0] NONE_BYTE  = 8'h00;

   // Mode register values.
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // A code group: symbols left aligned, dash = 1, dot = 0, unused bits 0.
   // Single-byte entries (space and '!') are literal and stand as themselves.
   typedef struct packed {
      logic       found;
      logic       lit;
      logic [2:0] len;
      logic [6:0] bits;
   } enc_type;

   typedef struct packed {
      logic       found;
      logic [7:0] ch;
   } dec_type;

   // One pending result burst: nsym symbol beats, then the final beat.
   typedef struct packed {
      logic [2:0] nsym;
      logic [6:0] bits;
      logic       lit;
      logic [7:0] sym_byte;
      logic [7:0] final_byte;
      logic       err;
   } burst_type;

   // Status of the result serializer as seen by the front end.
   typedef struct packed {
      logic busy;
      logic finishing;
   } beat_status_type;

   function automatic enc_type mk_enc(input logic [2:0] len, input logic [6:0] bits);
      enc_type e;
      e.found = 1'b1;
      e.lit   = 1'b0;
      e.len   = len;
      e.bits  = bits;
      return e;
   endfunction

   // Character to code group.
   function automatic enc_type enc_lookup(input logic [7:0] ch);
      enc_type e;
      e = '0;
      case (ch)
         8'h61, 8'h41:  e = mk_enc(3'd2, 7'b0100000);  // a
         8'd165, 8'd164: e = mk_enc(3'd4, 7'b0101000);
         8'h62, 8'h42:  e = mk_enc(3'd4, 7'b1000000);  // b
         8'h63, 8'h43:  e = mk_enc(3'd4, 7'b1010000);  // c
         8'd134, 8'd143: e = mk_enc(3'd5, 7'b1010000);
         8'h64, 8'h44:  e = mk_enc(3'd3, 7'b1000000);  // d
         8'h65, 8'h45:  e = mk_enc(3'd1, 7'b0000000);  // e
         8'd169, 8'd168: e = mk_enc(3'd5, 7'b0010000);
         8'h66, 8'h46:  e = mk_enc(3'd4, 7'b0010000);  // f
         8'h67, 8'h47:  e = mk_enc(3'd3, 7'b1100000);  // g
         8'h68, 8'h48:  e = mk_enc(3'd4, 7'b0000000);  // h
         8'h69, 8'h49:  e = mk_enc(3'd2, 7'b0000000);  // i
         8'h6A, 8'h4A:  e = mk_enc(3'd4, 7'b0111000);  // j
         8'h6B, 8'h4B:  e = mk_enc(3'd3, 7'b1010000);  // k
         8'h6C, 8'h4C:  e = mk_enc(3'd4, 7'b0100000);  // l
         8'd136, 8'd157: e = mk_enc(3'd5, 7'b0100100);
         8'h6D, 8'h4D:  e = mk_enc(3'd2, 7'b1100000);  // m
         8'h6E, 8'h4E:  e = mk_enc(3'd2, 7'b1000000);  // n
         8'd228, 8'd227: e = mk_enc(3'd5, 7'b1101100);
         8'h6F, 8'h4F:  e = mk_enc(3'd3, 7'b1110000);  // o
         8'd162, 8'd224: e = mk_enc(3'd4, 7'b1110000);
         8'h70, 8'h50:  e = mk_enc(3'd4, 7'b0110000);  // p
         8'h71, 8'h51:  e = mk_enc(3'd4, 7'b1101000);  // q
         8'h72, 8'h52:  e = mk_enc(3'd3, 7'b0100000);  // r
         8'h73, 8'h53:  e = mk_enc(3'd3, 7'b0000000);  // s
         8'd152, 8'd151: e = mk_enc(3'd7, 7'b0001000);
         8'h74, 8'h54:  e = mk_enc(3'd1, 7'b1000000);  // t
         8'h75, 8'h55:  e = mk_enc(3'd3, 7'b0010000);  // u
         8'h76, 8'h56:  e = mk_enc(3'd4, 7'b0001000);  // v
         8'h77, 8'h57:  e = mk_enc(3'd3, 7'b0110000);  // w
         8'h78, 8'h58:  e = mk_enc(3'd4, 7'b1001000);  // x
         8'h79, 8'h59:  e = mk_enc(3'd4, 7'b1011000);  // y
         8'h7A, 8'h5A:  e = mk_enc(3'd4, 7'b1100000);  // z
         8'd190, 8'd189: e = mk_enc(3'd5, 7'b1100100);
         8'd171, 8'd141: e = mk_enc(3'd6, 7'b1100100);
         8'h2E:         e = mk_enc(3'd6, 7'b0101010);  // .
         8'h2C:         e = mk_enc(3'd6, 7'b1100110);  // ,
         8'h3F:         e = mk_enc(3'd6, 7'b0011000);  // ?
         8'h3A:         e = mk_enc(3'd6, 7'b1110000);  // :
         8'h2D:         e = mk_enc(3'd6, 7'b1000010);  // -
         8'h30:         e = mk_enc(3'd5, 7'b1111100);
         8'h31:         e = mk_enc(3'd5, 7'b0111100);
         8'h32:         e = mk_enc(3'd5, 7'b0011100);
         8'h33:         e = mk_enc(3'd5, 7'b0001100);
         8'h34:         e = mk_enc(3'd5, 7'b0000100);
         8'h35:         e = mk_enc(3'd5, 7'b0000000);
         8'h36:         e = mk_enc(3'd5, 7'b1000000);
         8'h37:         e = mk_enc(3'd5, 7'b1100000);
         8'h38:         e = mk_enc(3'd5, 7'b1110000);
         8'h39:         e = mk_enc(3'd5, 7'b1111000);
         SPACE_BYTE, BANG_BYTE: begin
            e.found = 1'b1;
            e.lit   = 1'b1;
            e.len   = 3'd1;
            e.bits  = 7'b0000000;
         end
         default:       e = '0;
      endcase
      return e;
   endfunction

   // Dot/dash group to character; capitals share their group with the
   // lower case letter, which is the one returned.
   function automatic dec_type dec_lookup(input logic [2:0] len, input logic [6:0] bits);
      dec_type d;
      d.found = 1'b1;
      d.ch    = NONE_BYTE;
      case ({len, bits})
         {3'd2, 7'b0100000}: d.ch = 8'h61;
         {3'd4, 7'b0101000}: d.ch = 8'd165;
         {3'd4, 7'b1000000}: d.ch = 8'h62;
         {3'd4, 7'b1010000}: d.ch = 8'h63;
         {3'd5, 7'b1010000}: d.ch = 8'd134;
         {3'd3, 7'b1000000}: d.ch = 8'h64;
         {3'd1, 7'b0000000}: d.ch = 8'h65;
         {3'd5, 7'b0010000}: d.ch = 8'd169;
         {3'd4, 7'b0010000}: d.ch = 8'h66;
         {3'd3, 7'b1100000}: d.ch = 8'h67;
         {3'd4, 7'b0000000}: d.ch = 8'h68;
         {3'd2, 7'b0000000}: d.ch = 8'h69;
         {3'd4, 7'b0111000}: d.ch = 8'h6A;
         {3'd3, 7'b1010000}: d.ch = 8'h6B;
         {3'd4, 7'b0100000}: d.ch = 8'h6C;
         {3'd5, 7'b0100100}: d.ch = 8'd136;
         {3'd2, 7'b1100000}: d.ch = 8'h6D;
         {3'd2, 7'b1000000}: d.ch = 8'h6E;
         {3'd5, 7'b1101100}: d.ch = 8'd228;
         {3'd3, 7'b1110000}: d.ch = 8'h6F;
         {3'd4, 7'b1110000}: d.ch = 8'd162;
         {3'd4, 7'b0110000}: d.ch = 8'h70;
         {3'd4, 7'b1101000}: d.ch = 8'h71;
         {3'd3, 7'b0100000}: d.ch = 8'h72;
         {3'd3, 7'b0000000}: d.ch = 8'h73;
         {3'd7, 7'b0001000}: d.ch = 8'd152;
         {3'd1, 7'b1000000}: d.ch = 8'h74;
         {3'd3, 7'b0010000}: d.ch = 8'h75;
         {3'd4, 7'b0001000}: d.ch = 8'h76;
         {3'd3, 7'b0110000}: d.ch = 8'h77;
         {3'd4, 7'b1001000}: d.ch = 8'h78;
         {3'd4, 7'b1011000}: d.ch = 8'h79;
         {3'd4, 7'b1100000}: d.ch = 8'h7A;
         {3'd5, 7'b1100100}: d.ch = 8'd190;
         {3'd6, 7'b1100100}: d.ch = 8'd171;
         {3'd6, 7'b0101010}: d.ch = 8'h2E;
         {3'd6, 7'b1100110}: d.ch = 8'h2C;
         {3'd6, 7'b0011000}: d.ch = 8'h3F;
         {3'd6, 7'b1110000}: d.ch = 8'h3A;
         {3'd6, 7'b1000010}: d.ch = 8'h2D;
         {3'd5, 7'b1111100}: d.ch = 8'h30;
         {3'd5, 7'b0111100}: d.ch = 8'h31;
         {3'd5, 7'b0011100}: d.ch = 8'h32;
         {3'd5, 7'b0001100}: d.ch = 8'h33;
         {3'd5, 7'b0000100}: d.ch = 8'h34;
         {3'd5, 7'b0000000}: d.ch = 8'h35;
         {3'd5, 7'b1000000}: d.ch = 8'h36;
         {3'd5, 7'b1100000}: d.ch = 8'h37;
         {3'd5, 7'b1110000}: d.ch = 8'h38;
         {3'd5, 7'b1111000}: d.ch = 8'h39;
         default:            d.found = 1'b0;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/mtc_if.sv =====
// ----------------------------------------------------------------------------
// Morse text codec channel interfaces
// Valid/ready channels for the input bytes and the result beats.
// ----------------------------------------------------------------------------

// Input channel: one byte per beat.
interface mtc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// Result channel: one output byte per beat with last and error flags.
interface mtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       error;

   modport source (output valid, output out_byte, output last, output error, input ready);
   modport sink (input valid, input out_byte, input last, input error, output ready);
endinterface

// ===== rtl/morse_text_codec_unit.sv =====
// ----------------------------------------------------------------------------
// Morse text codec unit
// Byte stream Morse encoder and decoder over a fixed character table.
// ----------------------------------------------------------------------------
// Use:
// The req_if channel takes one byte per beat; rsp_if returns result beats of
// out_byte, last and error. The csr port writes the mode bit: 0 encodes each
// character into its dot/dash group followed by '|', 1 gathers bytes into a
// group and decodes it when '|' arrives. Write the mode only while idle.
// A byte that makes a result waits in the input register until the result
// register is free or sending its final beat, and is then loaded into it.
// An encoded character occupies the result channel for its group length
// plus one beats, or one error beat when it has no group; a decoded
// separator takes one beat; a decode byte inside a group makes no beat.
// The result register sends one beat per cycle while the receiver is ready,
// bounding the rate; the input register takes the next byte while a burst
// is still being sent. Reset clears the mode to encode, the pending byte,
// the result burst and the gathered group. When the receiver stalls, the
// current beat holds and the input side fills and then deasserts ready.
// ----------------------------------------------------------------------------
module morse_text_codec_unit (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_we,
   input  logic      csr_wdata,
   mtc_req_if.sink   req_if,
   mtc_rsp_if.source rsp_if
);

   // Mode register.
   logic mode_ff;
   logic mode_in;

   assign mode_in = csr_we ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mtc_pkg::MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Input register.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] in_byte_in;
   logic       in_mode_ff;
   logic       in_mode_in;
   logic       accept;
   logic       advance;
   logic       no_res;
   logic       is_sep;

   mtc_pkg::beat_status_type status;

   assign is_sep  = (in_byte_ff == mtc_pkg::SEP_BYTE);
   assign no_res  = (in_mode_ff == mtc_pkg::MODE_DECODE) && !is_sep;
   assign advance = in_valid_ff && (no_res || !status.busy || status.finishing);
   assign req_if.ready = !in_valid_ff || advance;
   assign accept  = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_mode_in  = in_mode_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.in_byte;
         in_mode_in  = mode_ff;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_mode_ff <= in_mode_in;
   end

   // Decode group.
   mtc_pkg::dec_type match;
   logic             grp_upd;
   logic             grp_clr;

   assign grp_upd = advance && no_res;
   assign grp_clr = advance && (in_mode_ff == mtc_pkg::MODE_DECODE) && is_sep;

   mtc_group u_group (
      .clock   (clock),
      .reset   (reset),
      .upd     (grp_upd),
      .clr     (grp_clr),
      .byte_in (in_byte_ff),
      .match   (match)
   );

   // Build the result burst for the pending byte.
   mtc_pkg::enc_type   enc;
   mtc_pkg::burst_type burst;
   logic               burst_load;

   assign enc        = mtc_pkg::enc_lookup(in_byte_ff);
   assign burst_load = advance && !no_res;

   always_comb begin
      burst.bits     = enc.bits;
      burst.lit      = enc.lit;
      burst.sym_byte = in_byte_ff;
      if (in_mode_ff == mtc_pkg::MODE_ENCODE) begin
         burst.nsym       = enc.found ? enc.len : 3'd0;
         burst.final_byte = mtc_pkg::SEP_BYTE;
         burst.err        = !enc.found;
      end else begin
         burst.nsym       = 3'd0;
         burst.final_byte = match.found ? match.ch : mtc_pkg::NONE_BYTE;
         burst.err        = !match.found;
      end
   end

   // Result serializer.
   mtc_beat_out u_beat_out (
      .clock  (clock),
      .reset  (reset),
      .load   (burst_load),
      .burst  (burst),
      .status (status),
      .rsp_if (rsp_if)
   );

endmodule

// ===== rtl/mtc_group.sv =====
// ----------------------------------------------------------------------------
// Morse text codec group gatherer
// Collects decode-mode bytes into a group and matches it against the table.
// ----------------------------------------------------------------------------
module mtc_group (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 upd,       // store one byte of the group
   input  logic                 clr,       // separator taken: clear the group
   input  logic [7:0]           byte_in,
   output mtc_pkg::dec_type     match
);

   logic [7:0] grp_ff [mtc_pkg::MAX_GROUP_LEN];
   logic [2:0] len_ff;
   logic [2:0] len_in;
   logic       ovf_ff;
   logic       ovf_in;
   logic       full;

   assign full = (len_ff == 3'(mtc_pkg::MAX_GROUP_LEN));

   // Group length and overflow flag.
   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (clr) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (upd) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   // Group bytes; only entries below the length are ever read.
   always_ff @(posedge clock) begin
      if (upd && !clr && !full) begin
         grp_ff[len_ff] <= byte_in;
      end
   end

   // Turn the stored bytes into a left-aligned dot/dash pattern.
   logic [6:0]       pat;
   logic             dd_ok;
   logic             lit_ok;
   mtc_pkg::dec_type tab;

   always_comb begin
      pat   = '0;
      dd_ok = 1'b1;
      for (int j = 0; j < mtc_pkg::MAX_GROUP_LEN; j++) begin
         if (3'(j) < len_ff) begin
            pat[6 - j] = (grp_ff[j] == mtc_pkg::DASH_BYTE);
            if (grp_ff[j] != mtc_pkg::DASH_BYTE && grp_ff[j] != mtc_pkg::DOT_BYTE) begin
               dd_ok = 1'b0;
            end
         end
      end
   end

   assign tab    = mtc_pkg::dec_lookup(len_ff, pat);
   assign lit_ok = (len_ff == 3'd1) &&
                   (grp_ff[0] == mtc_pkg::SPACE_BYTE || grp_ff[0] == mtc_pkg::BANG_BYTE);

   // Space and '!' stand for themselves; overflow never matches.
   always_comb begin
      match.found = 1'b0;
      match.ch    = mtc_pkg::NONE_BYTE;
      if (!ovf_ff) begin
         if (lit_ok) begin
            match.found = 1'b1;
            match.ch    = grp_ff[0];
         end else if (dd_ok && tab.found) begin
            match.found = 1'b1;
            match.ch    = tab.ch;
         end
      end
   end

endmodule

// ===== rtl/mtc_beat_out.sv =====
// ----------------------------------------------------------------------------
// Morse text codec result serializer
// Holds one result burst and sends it out one beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module mtc_beat_out (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  mtc_pkg::burst_type       burst,
   output mtc_pkg::beat_status_type status,
   mtc_rsp_if.source                rsp_if
);

   mtc_pkg::burst_type burst_ff;
   mtc_pkg::burst_type burst_in;
   logic               busy_ff;
   logic               busy_in;
   logic [2:0]         idx_ff;
   logic [2:0]         idx_in;
   logic               is_last;
   logic               take;

   assign is_last = (idx_ff == burst_ff.nsym);
   assign take    = busy_ff && rsp_if.ready;

   // Next burst state: load a new burst or step past the beat just taken.
   always_comb begin
      burst_in = burst_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      if (load) begin
         burst_in = burst;
         busy_in  = 1'b1;
         idx_in   = '0;
      end else if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in        = idx_ff + 3'd1;
            burst_in.bits = {burst_ff.bits[5:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

   // Beat payload: symbol beats, then the final beat with the flags.
   always_comb begin
      rsp_if.valid = busy_ff;
      rsp_if.last  = is_last;
      rsp_if.error = is_last && burst_ff.err;
      if (is_last) begin
         rsp_if.out_byte = burst_ff.final_byte;
      end else if (burst_ff.lit) begin
         rsp_if.out_byte = burst_ff.sym_byte;
      end else begin
         rsp_if.out_byte = burst_ff.bits[6] ? mtc_pkg::DASH_BYTE : mtc_pkg::DOT_BYTE;
      end
   end

   assign status.busy      = busy_ff;
   assign status.finishing = take && is_last;

endmodule

// ===== rtl/mtc_checker.sv =====
// ----------------------------------------------------------------------------
// Morse text codec port checker
// Assertions on the result channel of the codec, bound to the top level.
// ----------------------------------------------------------------------------
module mtc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_error
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
                                  $stable(rsp_last) && $stable(rsp_error))
      else $error("result beat changed while stalled");

   // Errors are flagged only on the final beat of an item.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last)
      else $error("error flag on a beat that is not last");

   // An error beat carries either the separator or a zero byte.
   a_err_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> (rsp_out_byte == mtc_pkg::SEP_BYTE ||
                                  rsp_out_byte == mtc_pkg::NONE_BYTE))
      else $error("error beat with an unexpected byte");

   // Reset empties the result register.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

endmodule

bind morse_text_codec_unit mtc_checker u_mtc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_out_byte (rsp_if.out_byte),
   .rsp_last     (rsp_if.last),
   .rsp_error    (rsp_if.error)
);

// ===== sim/tb_morse_text_codec_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse text codec unit testbench
// Drives character and Morse byte streams in both modes with random gaps on
// the input and random stalls on the result side. An in-bench model of the
// codec predicts the result beats, typed directed rows carry their own, and
// each beat is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_morse_text_codec_unit;

   // One result beat as it appears on the result channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } codec_beat_type;

   typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_type;

   // One row of the directed stimulus; typed rows carry their single beat.
   typedef struct packed {
      row_kind_type   kind;
      logic [7:0]     data;
      logic           typed;
      codec_beat_type beat;
   } dir_row_type;

   localparam int NUM_CHARS    = 87;
   localparam int NUM_DIRECTED = 25;
   localparam int MODE_SETTLE  = 4;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   mtc_req_if req_ch();
   mtc_rsp_if rsp_ch();

   morse_text_codec_unit uut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_if   (req_ch),
      .rsp_if   (rsp_ch)
   );

   // Character set in lookup order; the first entry with a matching group
   // is the one a decode returns.
   logic [7:0] text_chars [NUM_CHARS] = '{
      "a", 8'd165, "b", "c", 8'd134, "d", "e", 8'd169, "f", "g",
      "h", "i", "j", "k", "l", 8'd136, "m", "n", 8'd228, "o",
      8'd162, "p", "q", "r", "s", 8'd152, "t", "u", "v", "w",
      "x", "y", "z", 8'd190, 8'd171,
      "A", 8'd164, "B", "C", 8'd143, "D", "E", 8'd168, "F", "G",
      "H", "I", "J", "K", "L", 8'd157, "M", "N", 8'd227, "O",
      8'd224, "P", "Q", "R", "S", 8'd151, "T", "U", "V", "W",
      "X", "Y", "Z", 8'd189, 8'd141,
      " ", ".", ",", "?", ":", "-",
      "0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "!"
   };

   // Directed stimulus: extremes, literal entries, error cases and overflow.
   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_BYTE, mtc_pkg::NONE_BYTE,  1'b1, '{mtc_pkg::SEP_BYTE, 1'b1, 1'b1}},
      '{ROW_BYTE, 8'hFF,               1'b1, '{mtc_pkg::SEP_BYTE, 1'b1, 1'b1}},
      '{ROW_BYTE, "a",                 1'b0, '0},
      '{ROW_BYTE, 8'd152,              1'b0, '0},
      '{ROW_BYTE, mtc_pkg::SPACE_BYTE, 1'b0, '0},
      '{ROW_BYTE, mtc_pkg::BANG_BYTE,  1'b0, '0},
      '{ROW_BYTE, "Z",                 1'b0, '0},
      '{ROW_BYTE, mtc_pkg::SEP_BYTE,   1'b1, '{mtc_pkg::SEP_BYTE, 1'b1, 1'b1}},
      '{ROW_BYTE, 8'd141,              1'b0, '0},
      '{ROW_MODE, 8'(mtc_pkg::MODE_DECODE), 1'b0, '0},
      '{ROW_BYTE, mtc_pkg::SEP_BYTE,   1'b1, '{mtc_pkg::NONE_BYTE, 1'b1, 1'b1}},
      '{ROW_BYTE, mtc_pkg::DOT_BYTE,   1'b0, '0},
      '{ROW_BYTE, mtc_pkg::DASH_BYTE,  1'b0, '0},
      '{ROW_BYTE, mtc_pkg::SEP_BYTE,   1'b1, '{8'h61, 1'b1, 1'b0}},
      '{ROW_BYTE, mtc_pkg::NONE_BYTE,  1'b0, '0},
      '{ROW_BYTE, mtc_pkg::SEP_BYTE,   1'b1, '{mtc_pkg::NONE_BYTE, 1'b1, 1'b1}},
      '{ROW_BYTE, mtc_pkg::DOT_BYTE,   1'b0, '0},
      '{ROW_BYTE, mtc_pkg::DOT_BYTE,   1'b0, '0},
      '{ROW_BYTE, mtc_pkg::DOT_BYTE,   1'b0, '0},
      '{ROW_BYTE, mtc_pkg::DASH_BYTE,  1'b0, '0},
      '{ROW_BYTE, mtc_pkg::DOT_BYTE,   1'b0, '0},
      '{ROW_BYTE, mtc_pkg::DOT_BYTE,   1'b0, '0},
      '{ROW_BYTE, mtc_pkg::DOT_BYTE,   1'b0, '0},
      '{ROW_BYTE, mtc_pkg::DOT_BYTE,   1'b0, '0},
      '{ROW_BYTE, mtc_pkg::SEP_BYTE,   1'b1, '{mtc_pkg::NONE_BYTE, 1'b1, 1'b1}}
   };

   // Codec model state.
   logic       mode_now;
   logic [7:0] grp_store [mtc_pkg::MAX_GROUP_LEN];
   int         grp_len;
   logic       grp_overflow;

   codec_beat_type owed_beats [$];
   int             mismatch_count;
   int             send_idle_pct;
   int             recv_idle_pct;

   // Code group of a character, or an empty string when it has none.
   function automatic string morse_code_of(input logic [7:0] ch);
      string code;
      code = "";
      case (ch)
         "a", "A":       code = ".-";
         8'd165, 8'd164: code = ".-.-";
         "b", "B":       code = "-...";
         "c", "C":       code = "-.-.";
         8'd134, 8'd143: code = "-.-..";
         "d", "D":       code = "-..";
         "e", "E":       code = ".";
         8'd169, 8'd168: code = "..-..";
         "f", "F":       code = "..-.";
         "g", "G":       code = "--.";
         "h", "H":       code = "....";
         "i", "I":       code = "..";
         "j", "J":       code = ".---";
         "k", "K":       code = "-.-";
         "l", "L":       code = ".-..";
         8'd136, 8'd157: code = ".-..-";
         "m", "M":       code = "--";
         "n", "N":       code = "-.";
         8'd228, 8'd227: code = "--.--";
         "o", "O":       code = "---";
         8'd162, 8'd224: code = "---.";
         "p", "P":       code = ".--.";
         "q", "Q":       code = "--.-";
         "r", "R":       code = ".-.";
         "s", "S":       code = "...";
         8'd152, 8'd151: code = "...-...";
         "t", "T":       code = "-";
         "u", "U":       code = "..-";
         "v", "V":       code = "...-";
         "w", "W":       code = ".--";
         "x", "X":       code = "-..-";
         "y", "Y":       code = "-.--";
         "z", "Z":       code = "--..";
         8'd190, 8'd189: code = "--..-";
         8'd171, 8'd141: code = "--..-.";
         " ":            code = " ";
         ".":            code = ".-.-.-";
         ",":            code = "--..--";
         "?":            code = "..--..";
         ":":            code = "---...";
         "-":            code = "-....-";
         "0":            code = "-----";
         "1":            code = ".----";
         "2":            code = "..---";
         "3":            code = "...--";
         "4":            code = "....-";
         "5":            code = ".....";
         "6":            code = "-....";
         "7":            code = "--...";
         "8":            code = "---..";
         "9":            code = "----.";
         "!":            code = "!";
         default:        code = "";
      endcase
      return code;
   endfunction

   // Advances the codec model by one input byte and returns its beats.
   function automatic int morse_predict(input logic [7:0] b,
                                        output codec_beat_type beats [8]);
      string      code;
      logic       found;
      logic       hit;
      logic [7:0] ch;
      foreach (beats[k]) beats[k] = '0;
      // Encode: symbol beats, then the separator marked last.
      if (mode_now == mtc_pkg::MODE_ENCODE) begin
         code = morse_code_of(b);
         if (code.len() == 0) begin
            beats[0] = '{mtc_pkg::SEP_BYTE, 1'b1, 1'b1};
            return 1;
         end
         for (int j = 0; j < code.len(); j++) beats[j] = '{code[j], 1'b0, 1'b0};
         beats[code.len()] = '{mtc_pkg::SEP_BYTE, 1'b1, 1'b0};
         return code.len() + 1;
      end
      // Decode: gather the group until a separator comes.
      if (b != mtc_pkg::SEP_BYTE) begin
         if (grp_len < mtc_pkg::MAX_GROUP_LEN) begin
            grp_store[grp_len] = b;
            grp_len++;
         end else begin
            grp_overflow = 1'b1;
         end
         return 0;
      end
      found = 1'b0;
      ch    = mtc_pkg::NONE_BYTE;
      if (!grp_overflow) begin
         for (int i = 0; i < NUM_CHARS && !found; i++) begin
            code = morse_code_of(text_chars[i]);
            if (code.len() == grp_len) begin
               hit = 1'b1;
               for (int j = 0; j < grp_len; j++) begin
                  if (code[j] != grp_store[j]) hit = 1'b0;
               end
               if (hit) begin
                  found = 1'b1;
                  ch    = text_chars[i];
               end
            end
         end
      end
      grp_len      = 0;
      grp_overflow = 1'b0;
      beats[0] = found ? '{ch, 1'b1, 1'b0} : '{mtc_pkg::NONE_BYTE, 1'b1, 1'b1};
      return 1;
   endfunction

   // Offers one byte with random gaps and queues its beats once accepted.
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input codec_beat_type typed_beat);
      codec_beat_type beats [8];
      int             n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      n = morse_predict(b, beats);
      if (typed) begin
         owed_beats.push_back(typed_beat);
      end else begin
         for (int k = 0; k < n; k++) owed_beats.push_back(beats[k]);
      end
   endtask

   // Holds the input off until every owed beat has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (owed_beats.size() != 0);
   endtask

   // Mode writes happen only with the block idle.
   task automatic write_mode(input logic value);
      drain_results();
      repeat (MODE_SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we   <= 1'b0;
      mode_now = value;
   endtask

   // Random characters, mostly from the table, the rest any byte.
   task automatic send_random_text(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 75) b = text_chars[$urandom_range(NUM_CHARS - 1)];
         else b = 8'($urandom_range(255));
         send_byte(b, 1'b0, '0);
         // Once per segment the sender waits for the results to catch up.
         if (i == count / 2) drain_results();
      end
   endtask

   // Random groups: mostly valid codes, with overflowed, garbled and noisy ones.
   task automatic send_random_groups(input int count);
      string code;
      int    pick;
      int    n;
      for (int g = 0; g < count; g++) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            code = morse_code_of(text_chars[$urandom_range(NUM_CHARS - 1)]);
            for (int j = 0; j < code.len(); j++) send_byte(code[j], 1'b0, '0);
            send_byte(mtc_pkg::SEP_BYTE, 1'b0, '0);
         end else if (pick < 80) begin
            n = $urandom_range(10, 8);
            for (int j = 0; j < n; j++)
               send_byte($urandom_range(1) ? mtc_pkg::DASH_BYTE : mtc_pkg::DOT_BYTE,
                         1'b0, '0);
            send_byte(mtc_pkg::SEP_BYTE, 1'b0, '0);
         end else if (pick < 90) begin
            n = $urandom_range(7);
            for (int j = 0; j < n; j++)
               send_byte($urandom_range(1) ? mtc_pkg::DASH_BYTE : mtc_pkg::DOT_BYTE,
                         1'b0, '0);
            send_byte(mtc_pkg::SEP_BYTE, 1'b0, '0);
         end else begin
            n = $urandom_range(3, 1);
            for (int j = 0; j < n; j++) send_byte(8'($urandom_range(255)), 1'b0, '0);
            if ($urandom_range(1)) send_byte(mtc_pkg::SEP_BYTE, 1'b0, '0);
         end
      end
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls and an in-order check of every beat.
   initial begin
      codec_beat_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (owed_beats.size() == 0) begin
               $display("%0t: beat out_byte %02h last %b error %b arrived with none owed",
                        $time, rsp_ch.out_byte, rsp_ch.last, rsp_ch.error);
               mismatch_count++;
            end else begin
               want = owed_beats.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.out_byte, rsp_ch.out_byte);
                  mismatch_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_ch.last);
                  mismatch_count++;
               end
               if (rsp_ch.error !== want.error) begin
                  $display("%0t: error expected %b actual %b", $time, want.error, rsp_ch.error);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Run limit.
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Stimulus: directed rows, then three idling phases of random traffic.
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      mode_now       = mtc_pkg::MODE_ENCODE;
      grp_len        = 0;
      grp_overflow   = 1'b0;
      mismatch_count = 0;
      foreach (grp_store[k]) grp_store[k] = 8'h00;
      send_idle_pct = 29;
      recv_idle_pct = 85;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_MODE) write_mode(directed_rows[i].data[0]);
         else send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].beat);
      end

      for (int p = 0; p < 3; p++) begin
         if (p == 1) begin
            send_idle_pct = 85;
            recv_idle_pct = 29;
         end else if (p == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_mode(mtc_pkg::MODE_ENCODE);
         send_random_text(30);
         write_mode(mtc_pkg::MODE_DECODE);
         send_random_groups(10);
      end

      drain_results();
      repeat (MODE_SETTLE * 4) @(posedge clock);
      if (mismatch_count == 0 && owed_beats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mtc_pkg.sv
rtl/mtc_if.sv
rtl/mtc_group.sv
rtl/mtc_beat_out.sv
rtl/morse_text_codec_unit.sv
rtl/mtc_checker.sv
sim/tb_morse_text_codec_unit.sv
